[sv/ordered_item_list_engine_assert.svh]
// ----------------------------------------------------------------------------
// Ordered item list engine: assertion macros
// Shared concurrent check forms for the list engine modules.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ITEM_LIST_ENGINE_ASSERT_SVH
`define ORDERED_ITEM_LIST_ENGINE_ASSERT_SVH

// same-cycle implication
`define OILE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list engine: same-cycle check failed");

// next-cycle implication
`define OILE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list engine: next-cycle check failed");

`endif

[sv/oile_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered item list engine package
// Sizes, command codes, controller states and control bundle.
// ----------------------------------------------------------------------------
package oile_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W       = 5;
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int CMD_W       = 3;
  localparam int ID_W        = 8;
  localparam int TYPE_W      = 8;
  localparam int TIX_W       = 5;
  localparam int FPOS_W      = 4;
  localparam int SIZE_W      = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT_AT    = 3'd0,
    CMD_APPEND       = 3'd1,
    CMD_GET_AT       = 3'd2,
    CMD_FIND_ITEM    = 3'd3,
    CMD_REMOVE_ITEM  = 3'd4,
    CMD_CLEAR        = 3'd5,
    CMD_TYPE_PRESENT = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic capture;
    logic search;
    logic apply;
  } ctrl_t;

endpackage

[sv/oile_ctrl.sv]
// ----------------------------------------------------------------------------
// Ordered item list engine controller
// Sequences capture, search and apply; owns the handshakes.
// ----------------------------------------------------------------------------
module oile_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output oile_pkg::ctrl_t ctrl_o
);

  `include "ordered_item_list_engine_assert.svh"

  oile_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      oile_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = oile_pkg::ST_SEARCH;
      end
      oile_pkg::ST_SEARCH: begin
        state_nxt = oile_pkg::ST_APPLY;
      end
      oile_pkg::ST_APPLY: begin
        if (out_free) state_nxt = oile_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = oile_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = (state_r == oile_pkg::ST_IDLE);
    ctrl_o.capture = in_valid && in_ready;
    ctrl_o.search  = (state_r == oile_pkg::ST_SEARCH);
    ctrl_o.apply   = (state_r == oile_pkg::ST_APPLY) && out_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl_o.apply) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oile_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `OILE_ASSERT_NXT(a_accept_to_search, clk, rst_n, ctrl_o.capture,
                   state_r == oile_pkg::ST_SEARCH)
  `OILE_ASSERT_NXT(a_search_to_apply, clk, rst_n, state_r == oile_pkg::ST_SEARCH,
                   state_r == oile_pkg::ST_APPLY)
  `OILE_ASSERT_NXT(a_apply_shows_result, clk, rst_n, ctrl_o.apply,
                   out_valid_r && state_r == oile_pkg::ST_IDLE)

endmodule

[sv/oile_dp.sv]
// ----------------------------------------------------------------------------
// Ordered item list engine datapath
// Entry cells with parallel match, shift insert/remove and result register.
// ----------------------------------------------------------------------------
module oile_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  oile_pkg::ctrl_t                    ctrl_i,
  input  logic [oile_pkg::CMD_W-1:0]         in_cmd,
  input  logic [oile_pkg::ID_W-1:0]          in_item_id,
  input  logic [oile_pkg::TYPE_W-1:0]        in_item_type,
  input  logic signed [oile_pkg::TIX_W-1:0]  in_table_index,
  input  logic [oile_pkg::POS_W-1:0]         in_position,
  output logic                               out_ok,
  output logic [oile_pkg::FPOS_W-1:0]        out_found_position,
  output logic [oile_pkg::ID_W-1:0]          out_item_id,
  output logic [oile_pkg::TYPE_W-1:0]        out_item_type,
  output logic signed [oile_pkg::TIX_W-1:0]  out_table_index,
  output logic [oile_pkg::SIZE_W-1:0]        out_list_size
);

  `include "ordered_item_list_engine_assert.svh"

  localparam int N = oile_pkg::MAX_ENTRIES;

  // captured transaction
  oile_pkg::cmd_t                 cmd_r;
  logic [oile_pkg::ID_W-1:0]      id_r;
  logic [oile_pkg::TYPE_W-1:0]    type_r;
  logic [oile_pkg::TIX_W-1:0]     tix_r;
  logic [oile_pkg::POS_W-1:0]     pos_r;

  // entry cells
  logic [oile_pkg::ID_W-1:0]      ids_r   [N];
  logic [oile_pkg::TYPE_W-1:0]    types_r [N];
  logic [oile_pkg::TIX_W-1:0]     tixs_r  [N];
  logic [oile_pkg::ID_W-1:0]      ids_nxt   [N];
  logic [oile_pkg::TYPE_W-1:0]    types_nxt [N];
  logic [oile_pkg::TIX_W-1:0]     tixs_nxt  [N];
  logic [oile_pkg::CNT_W-1:0]     count_r, count_nxt;

  // search results
  logic                           hit_r, hit_nxt;
  logic [oile_pkg::IDX_W-1:0]     at_r, at_nxt;
  logic                           tpres_r, tpres_nxt;

  // result register
  logic                           ok_r, ok_nxt;
  logic [oile_pkg::FPOS_W-1:0]    fpos_r, fpos_nxt;
  logic [oile_pkg::ID_W-1:0]      oid_r, oid_nxt;
  logic [oile_pkg::TYPE_W-1:0]    otype_r, otype_nxt;
  logic [oile_pkg::TIX_W-1:0]     otix_r, otix_nxt;
  logic [oile_pkg::SIZE_W-1:0]    size_r, size_nxt;

  logic [oile_pkg::CMP_W-1:0]     cnt_ext, pos_ext, ins_pos, at_ext;
  logic [oile_pkg::IDX_W-1:0]     rd_idx;
  logic                           full, is_ins, ins_ok, rem_ok;

  assign cnt_ext = oile_pkg::CMP_W'(count_r);
  assign pos_ext = oile_pkg::CMP_W'(pos_r);
  assign at_ext  = oile_pkg::CMP_W'(at_r);
  assign rd_idx  = oile_pkg::IDX_W'(pos_ext);
  assign full    = (count_r == oile_pkg::CNT_W'(N));
  assign is_ins  = (cmd_r == oile_pkg::CMD_INSERT_AT) || (cmd_r == oile_pkg::CMD_APPEND);
  assign ins_pos = (cmd_r == oile_pkg::CMD_APPEND) ? cnt_ext : pos_ext;
  assign ins_ok  = is_ins && !full && (ins_pos <= cnt_ext);
  assign rem_ok  = (cmd_r == oile_pkg::CMD_REMOVE_ITEM) && hit_r;

  // parallel match over live cells, first id match wins
  always_comb begin
    hit_nxt   = 1'b0;
    at_nxt    = '0;
    tpres_nxt = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (oile_pkg::CMP_W'(i) < cnt_ext) begin
        if (ids_r[i] == id_r) begin
          hit_nxt = 1'b1;
          at_nxt  = oile_pkg::IDX_W'(i);
        end
        if (types_r[i] == type_r) tpres_nxt = 1'b1;
      end
    end
  end

  // shift insert / shift remove
  always_comb begin
    for (int i = 0; i < N; i++) begin
      ids_nxt[i]   = ids_r[i];
      types_nxt[i] = types_r[i];
      tixs_nxt[i]  = tixs_r[i];
      if (ins_ok) begin
        if (oile_pkg::CMP_W'(i) == ins_pos) begin
          ids_nxt[i]   = id_r;
          types_nxt[i] = type_r;
          tixs_nxt[i]  = tix_r;
        end else if (oile_pkg::CMP_W'(i) > ins_pos && oile_pkg::CMP_W'(i) <= cnt_ext) begin
          ids_nxt[i]   = ids_r[(i == 0) ? 0 : i - 1];
          types_nxt[i] = types_r[(i == 0) ? 0 : i - 1];
          tixs_nxt[i]  = tixs_r[(i == 0) ? 0 : i - 1];
        end
      end else if (rem_ok) begin
        if (oile_pkg::CMP_W'(i) >= at_ext && oile_pkg::CMP_W'(i + 1) < cnt_ext) begin
          ids_nxt[i]   = ids_r[(i == N - 1) ? i : i + 1];
          types_nxt[i] = types_r[(i == N - 1) ? i : i + 1];
          tixs_nxt[i]  = tixs_r[(i == N - 1) ? i : i + 1];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    ok_nxt    = 1'b0;
    fpos_nxt  = '0;
    oid_nxt   = '0;
    otype_nxt = '0;
    otix_nxt  = '0;
    unique case (cmd_r)
      oile_pkg::CMD_INSERT_AT, oile_pkg::CMD_APPEND: begin
        ok_nxt = ins_ok;
        if (ins_ok) count_nxt = count_r + 1'b1;
      end
      oile_pkg::CMD_GET_AT: begin
        if (pos_ext < cnt_ext) begin
          ok_nxt    = 1'b1;
          oid_nxt   = ids_r[rd_idx];
          otype_nxt = types_r[rd_idx];
          otix_nxt  = tixs_r[rd_idx];
        end
      end
      oile_pkg::CMD_FIND_ITEM: begin
        ok_nxt = hit_r;
        if (hit_r) fpos_nxt = oile_pkg::FPOS_W'(at_ext);
      end
      oile_pkg::CMD_REMOVE_ITEM: begin
        ok_nxt = hit_r;
        if (hit_r) count_nxt = count_r - 1'b1;
      end
      oile_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      oile_pkg::CMD_TYPE_PRESENT: begin
        ok_nxt = tpres_r;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
    size_nxt = oile_pkg::SIZE_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl_i.apply) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.capture) begin
      cmd_r  <= oile_pkg::cmd_t'(in_cmd);
      id_r   <= in_item_id;
      type_r <= in_item_type;
      tix_r  <= in_table_index;
      pos_r  <= in_position;
    end
    if (ctrl_i.search) begin
      hit_r   <= hit_nxt;
      at_r    <= at_nxt;
      tpres_r <= tpres_nxt;
    end
    if (ctrl_i.apply) begin
      for (int i = 0; i < N; i++) begin
        ids_r[i]   <= ids_nxt[i];
        types_r[i] <= types_nxt[i];
        tixs_r[i]  <= tixs_nxt[i];
      end
      ok_r    <= ok_nxt;
      fpos_r  <= fpos_nxt;
      oid_r   <= oid_nxt;
      otype_r <= otype_nxt;
      otix_r  <= otix_nxt;
      size_r  <= size_nxt;
    end
  end

  assign out_ok             = ok_r;
  assign out_found_position = fpos_r;
  assign out_item_id        = oid_r;
  assign out_item_type      = otype_r;
  assign out_table_index    = $signed(otix_r);
  assign out_list_size      = size_r;

  `OILE_ASSERT_IMP(a_count_bounded, clk, rst_n, 1'b1,
                   count_r <= oile_pkg::CNT_W'(N))
  `OILE_ASSERT_NXT(a_insert_grows, clk, rst_n, ctrl_i.apply && ins_ok,
                   count_r == oile_pkg::CNT_W'($past(count_r) + 1'b1))
  `OILE_ASSERT_NXT(a_remove_shrinks, clk, rst_n, ctrl_i.apply && rem_ok,
                   count_r == oile_pkg::CNT_W'($past(count_r) - 1'b1))

endmodule

[sv/ordered_item_list_engine.sv]
// ----------------------------------------------------------------------------
// Ordered item list engine
// Bounded ordered list of (id, type, table index) entries, one command
// per transaction, one result per command.
//
// Input channel in_*: valid/ready, one command per transaction. in_ready is
// high while the engine waits for a command, also while the previous result
// still waits on the output.
// Output channel out_*: valid/ready, one result per command; out_list_size
// is the entry count after the command.
// Each command passes in order through capture, a parallel match over the
// entry cells, and shift/update into the result register; a new command is
// taken only once the previous one has left the update step.
// A stalled receiver holds the result register; the engine then takes the
// next command and parks it in the update step until the result is taken.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; entry contents are left as they are and never read until written.
// ----------------------------------------------------------------------------
module ordered_item_list_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [oile_pkg::CMD_W-1:0]         in_cmd,
  input  logic [oile_pkg::ID_W-1:0]          in_item_id,
  input  logic [oile_pkg::TYPE_W-1:0]        in_item_type,
  input  logic signed [oile_pkg::TIX_W-1:0]  in_table_index,
  input  logic [oile_pkg::POS_W-1:0]         in_position,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_ok,
  output logic [oile_pkg::FPOS_W-1:0]        out_found_position,
  output logic [oile_pkg::ID_W-1:0]          out_item_id,
  output logic [oile_pkg::TYPE_W-1:0]        out_item_type,
  output logic signed [oile_pkg::TIX_W-1:0]  out_table_index,
  output logic [oile_pkg::SIZE_W-1:0]        out_list_size
);

  oile_pkg::ctrl_t ctrl;

  oile_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl_o    (ctrl)
  );

  oile_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl_i             (ctrl),
    .in_cmd             (in_cmd),
    .in_item_id         (in_item_id),
    .in_item_type       (in_item_type),
    .in_table_index     (in_table_index),
    .in_position        (in_position),
    .out_ok             (out_ok),
    .out_found_position (out_found_position),
    .out_item_id        (out_item_id),
    .out_item_type      (out_item_type),
    .out_table_index    (out_table_index),
    .out_list_size      (out_list_size)
  );

endmodule
